// ----- hw/rtl/sorted_table_binary_search_unit_assert.svh -----
// Assertion macros used by the sorted table search controller
`ifndef SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH
`define SORTED_TABLE_BINARY_SEARCH_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset
`define STBS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sorted table search: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset
`define STBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sorted table search: next-cycle check failed");

`endif

// ----- hw/rtl/stbs_pkg.sv -----
// Package with sizes, beat types and helpers for the sorted table search unit
`default_nettype none

package stbs_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;

   typedef enum logic {
      ACT_LOAD   = 1'b0,
      ACT_SEARCH = 1'b1
   } stbs_action_type;

   typedef struct packed {
      stbs_action_type            action;
      logic signed [VALUE_W-1:0]  value;
      logic                       last;
   } stbs_req_type;

   typedef struct packed {
      logic              found;
      logic [POS_W-1:0]  position;
      logic              table_ok;
   } stbs_rsp_type;

   // Table memory access for one cycle
   typedef struct packed {
      logic                       wr_en;
      logic [IDX_W-1:0]           wr_addr;
      logic signed [VALUE_W-1:0]  wr_data;
      logic                       rd_en;
      logic [IDX_W-1:0]           rd_addr;
   } stbs_ram_cmd_type;

   // Midpoint of [lo, hi1 - 1], rounded down; caller guarantees lo < hi1
   function automatic logic [IDX_W-1:0] probe_index(input logic [CNT_W-1:0] lo,
                                                     input logic [CNT_W-1:0] hi1);
      logic [CNT_W:0] sum;
      sum = {1'b0, lo} + {1'b0, hi1} - 1'b1;
      return sum[IDX_W:1];
   endfunction

   // Report an entry index in the fixed position width, masked
   function automatic logic [POS_W-1:0] to_position(input logic [IDX_W-1:0] idx);
      logic [IDX_W+POS_W-1:0] wide;
      wide = (IDX_W + POS_W)'(idx);
      return wide[POS_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/stbs_table_ram.sv -----
// Table storage: one write port, one read port with registered read data
`default_nettype none

module stbs_table_ram
   import stbs_pkg::*;
(
   input  wire logic                       clock,
   input  wire stbs_ram_cmd_type           ram_cmd,
   output logic signed [VALUE_W-1:0]       rd_data
);

   logic signed [VALUE_W-1:0] mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   // Write one entry per cycle
   always_ff @(posedge clock) begin
      if (ram_cmd.wr_en) begin
         mem[ram_cmd.wr_addr] <= ram_cmd.wr_data;
      end
   end

   // Registered read; data shows in the cycle after the read is issued
   always_ff @(posedge clock) begin
      if (ram_cmd.rd_en) begin
         rd_data_ff <= mem[ram_cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stbs_ctrl.sv -----
// Load bookkeeping and binary search sequencer over the table memory
`default_nettype none

module stbs_ctrl
   import stbs_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire stbs_req_type               req_item,
   output logic                            rsp_valid,
   output stbs_rsp_type                    rsp_item,
   output stbs_ram_cmd_type                ram_cmd,
   input  wire logic signed [VALUE_W-1:0]  ram_rd_data
);

`include "sorted_table_binary_search_unit_assert.svh"

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_PROBE = 2'b10
   } stbs_state_type;

   stbs_state_type             state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       order_ff, order_in;
   logic                       open_ff, open_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   stbs_rsp_type               rsp_ff, rsp_in;
   logic signed [VALUE_W-1:0]  prev_ff, prev_in;
   logic signed [VALUE_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]           lo_ff, lo_in;
   logic [CNT_W-1:0]           hi1_ff, hi1_in;
   logic [IDX_W-1:0]           mid_ff, mid_in;

   logic                       accept;
   logic [CNT_W-1:0]           load_count;
   logic                       load_order;
   logic                       load_room;
   logic                       load_ascending;
   logic                       key_above;
   logic                       key_below;
   logic [CNT_W-1:0]           lo_next;
   logic [CNT_W-1:0]           hi1_next;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // A load beat after a closed load starts a fresh table
   assign load_count     = open_ff ? count_ff : '0;
   assign load_order     = open_ff ? order_ff : 1'b1;
   assign load_room      = (load_count < CNT_W'(DEPTH));
   assign load_ascending = (load_count == '0) || (req_item.value > prev_ff);

   // Narrow the window around the entry read for the current probe
   assign key_above = (ram_rd_data < key_ff);
   assign key_below = (ram_rd_data > key_ff);
   assign lo_next   = key_above ? CNT_W'(mid_ff) + 1'b1 : lo_ff;
   assign hi1_next  = key_below ? CNT_W'(mid_ff) : hi1_ff;

   // Sequence loads and search probes
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      order_in     = order_ff;
      open_in      = open_ff;
      prev_in      = prev_ff;
      key_in       = key_ff;
      lo_in        = lo_ff;
      hi1_in       = hi1_ff;
      mid_in       = mid_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_cmd      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.action == ACT_LOAD) begin
                  open_in = !req_item.last;
                  if (load_room) begin
                     order_in        = load_order && load_ascending;
                     count_in        = load_count + 1'b1;
                     prev_in         = req_item.value;
                     ram_cmd.wr_en   = 1'b1;
                     ram_cmd.wr_addr = load_count[IDX_W-1:0];
                     ram_cmd.wr_data = req_item.value;
                  end else begin
                     // Drop the value, table overflowed
                     order_in = 1'b0;
                     count_in = load_count;
                  end
                  rsp_valid_in    = 1'b1;
                  rsp_in.found    = 1'b0;
                  rsp_in.position = '0;
                  rsp_in.table_ok = order_in;
               end else begin
                  key_in = req_item.value;
                  if (count_ff == '0) begin
                     rsp_valid_in    = 1'b1;
                     rsp_in.found    = 1'b0;
                     rsp_in.position = '0;
                     rsp_in.table_ok = order_ff;
                  end else begin
                     lo_in           = '0;
                     hi1_in          = count_ff;
                     mid_in          = probe_index('0, count_ff);
                     ram_cmd.rd_en   = 1'b1;
                     ram_cmd.rd_addr = mid_in;
                     state_in        = ST_PROBE;
                  end
               end
            end
         end
         ST_PROBE: begin
            lo_in  = lo_next;
            hi1_in = hi1_next;
            if (!key_above && !key_below) begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b1;
               rsp_in.position = to_position(mid_ff);
               rsp_in.table_ok = order_ff;
               state_in        = ST_IDLE;
            end else if (lo_next < hi1_next) begin
               mid_in          = probe_index(lo_next, hi1_next);
               ram_cmd.rd_en   = 1'b1;
               ram_cmd.rd_addr = mid_in;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_in.found    = 1'b0;
               rsp_in.position = '0;
               rsp_in.table_ok = order_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         order_ff     <= 1'b1;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         order_ff     <= order_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and search window
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      prev_ff <= prev_in;
      key_ff  <= key_in;
      lo_ff   <= lo_in;
      hi1_ff  <= hi1_in;
      mid_ff  <= mid_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `STBS_ASSERT_NOW(a_rsp_has_cause, rsp_valid_ff, $past(accept) || $past(state_ff == ST_PROBE))
   `STBS_ASSERT_NOW(a_found_from_probe, rsp_valid_ff && rsp_ff.found, $past(state_ff == ST_PROBE))
   `STBS_ASSERT_NOW(a_no_rw_overlap, 1'b1, !(ram_cmd.wr_en && ram_cmd.rd_en))
   `STBS_ASSERT_NOW(a_count_in_range, 1'b1, count_ff <= CNT_W'(DEPTH))
   `STBS_ASSERT_NOW(a_window_open, state_ff == ST_PROBE, lo_ff < hi1_ff)
   `STBS_ASSERT_NEXT(a_probe_reads, state_ff == ST_PROBE && !rsp_valid_in, state_ff == ST_PROBE)

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_table_binary_search_unit.sv -----
// Top level of the sorted table binary search unit
//
//   channel   handshake            beat type       direction
//   request   start, busy          stbs_req_type   in
//   response  rsp_valid (strobe)   stbs_rsp_type   out
//
// A load beat is taken while busy is low; its response shows in the next cycle
// and busy stays low, so loads can arrive back to back.
// A search beat holds busy while it probes, at most floor(log2(count)) + 1
// probes (5 at a depth of 16); each probe is one read of the table memory port.
// The response of a search shows in the cycle after the last probe.
// Synchronous reset empties the table at once; the response strobe is never held.
`default_nettype none

module sorted_table_binary_search_unit
   import stbs_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire stbs_req_type  req_item,
   output logic               rsp_valid,
   output stbs_rsp_type       rsp_item
);

   stbs_ram_cmd_type           ram_cmd;
   logic signed [VALUE_W-1:0]  ram_rd_data;

   stbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item),
      .ram_cmd     (ram_cmd),
      .ram_rd_data (ram_rd_data)
   );

   stbs_table_ram u_table_ram (
      .clock   (clock),
      .ram_cmd (ram_cmd),
      .rd_data (ram_rd_data)
   );

endmodule

`default_nettype wire
